// File: hdl/amf_pkg.sv
// ============================================================================
// amf_pkg: shared types for the array mode finder
// Item structs for the element input channel and the mode result channel.
// ============================================================================
`default_nettype none

package amf_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // One element of the data set
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } elem_item_t;

    // One modal value of the set
    typedef struct packed {
        logic [DATA_W-1:0]  mode_value;
        logic [COUNT_W-1:0] max_count;
        logic               overflow;
        logic               final_res;
    } mode_item_t;

endpackage : amf_pkg

`default_nettype wire

// File: hdl/amf_ram.sv
// ============================================================================
// amf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. No reset on the contents.
// ============================================================================
`default_nettype none

module amf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : amf_ram

`default_nettype wire

// File: hdl/array_mode_finder.sv
// ============================================================================
// array_mode_finder: statistical mode of a set of signed integers
// Elements load at one item per cycle while the block is in its load state.
// After the last element, n stored elements are bubble sorted through one
// comparator and the element RAM port; two run-length scans follow. Results
// leave from an output register, and the scan pauses while that register is
// stalled.
// Reset (async, active low) empties the set and clears the overflow flag.
// ============================================================================
`default_nettype none

module array_mode_finder #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // element channel
    input  wire logic                elem_valid,
    output logic                     elem_stall,
    input  wire amf_pkg::elem_item_t elem,
    // mode result channel
    output logic                     mode_valid,
    input  wire logic                mode_stall,
    output amf_pkg::mode_item_t      mode
);

    import amf_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_RD0,
        S_SORT_LD,
        S_SORT_STEP,
        S_SORT_END,
        S_CNT_RD0,
        S_CNT_FIRST,
        S_CNT_SCAN
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic              dropped_reg;
    logic [CW-1:0]     n_reg;
    logic [AW-1:0]     hi_reg;
    logic [AW-1:0]     j_reg;
    logic [CW-1:0]     k_reg;
    logic [DATA_W-1:0] carry_reg;
    logic [DATA_W-1:0] prev_reg;
    logic [CW-1:0]     run_reg;
    logic [CW-1:0]     best_reg;
    logic [CW-1:0]     ties_reg;
    logic [CW-1:0]     emitted_reg;
    logic              pass2_reg;
    logic              out_valid_reg;
    mode_item_t        out_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              has_room;
    logic [CW-1:0]     n_close;
    logic              lt;
    logic [CW-1:0]     k_inc;
    logic [CW-1:0]     emitted_inc;
    logic              at_end;
    logic              run_close;
    logic              qualifies;
    logic              out_free;
    logic              go;

    amf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare and scan control
    assign has_room    = (count_reg < MAX_CNT);
    assign n_close     = has_room ? count_reg + 1'b1 : count_reg;
    assign lt          = ($signed(ram_rdata) < $signed(carry_reg));
    assign k_inc       = k_reg + 1'b1;
    assign emitted_inc = emitted_reg + 1'b1;
    assign at_end      = (k_reg == n_reg);
    assign run_close   = at_end || (ram_rdata != prev_reg);
    assign qualifies   = pass2_reg && run_close && (run_reg == best_reg);
    assign out_free    = !out_valid_reg || !mode_stall;
    assign go          = !qualifies || out_free;

    assign elem_stall  = (state_reg != S_LOAD);
    assign mode_valid  = out_valid_reg;
    assign mode        = out_reg;

    // RAM port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = elem.value;
        ram_raddr = '0;
        case (state_reg)
            S_LOAD:
            begin
                ram_we    = elem_valid && has_room;
                ram_waddr = count_reg[AW-1:0];
            end
            S_SORT_RD0:
            begin
                ram_raddr = '0;
            end
            S_SORT_LD:
            begin
                ram_raddr = AW'(1);
            end
            S_SORT_STEP:
            begin
                // smaller value settles one slot down, larger rides on
                ram_we    = 1'b1;
                ram_waddr = j_reg - 1'b1;
                ram_wdata = lt ? ram_rdata : carry_reg;
                ram_raddr = j_reg + 1'b1;
            end
            S_SORT_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = carry_reg;
            end
            S_CNT_RD0:
            begin
                ram_raddr = '0;
            end
            S_CNT_FIRST:
            begin
                ram_raddr = AW'(1);
            end
            S_CNT_SCAN:
            begin
                // hold the address while waiting on the output register
                ram_raddr = go ? k_inc[AW-1:0] : k_reg[AW-1:0];
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            pass2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !mode_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (elem_valid)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (elem.last)
                        begin
                            n_reg       <= n_close;
                            hi_reg      <= AW'(n_close - 1'b1);
                            pass2_reg   <= 1'b0;
                            best_reg    <= '0;
                            ties_reg    <= '0;
                            emitted_reg <= '0;
                            state_reg   <= (n_close > CW'(1)) ? S_SORT_RD0 : S_CNT_RD0;
                        end
                    end
                end
                S_SORT_RD0:
                begin
                    state_reg <= S_SORT_LD;
                end
                S_SORT_LD:
                begin
                    carry_reg <= ram_rdata;
                    j_reg     <= AW'(1);
                    state_reg <= S_SORT_STEP;
                end
                S_SORT_STEP:
                begin
                    carry_reg <= lt ? carry_reg : ram_rdata;
                    if (j_reg == hi_reg)
                    begin
                        state_reg <= S_SORT_END;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_SORT_END:
                begin
                    // largest of this pass is now in place
                    hi_reg    <= hi_reg - 1'b1;
                    state_reg <= (hi_reg == AW'(1)) ? S_CNT_RD0 : S_SORT_RD0;
                end
                S_CNT_RD0:
                begin
                    state_reg <= S_CNT_FIRST;
                end
                S_CNT_FIRST:
                begin
                    prev_reg  <= ram_rdata;
                    run_reg   <= CW'(1);
                    k_reg     <= CW'(1);
                    state_reg <= S_CNT_SCAN;
                end
                S_CNT_SCAN:
                begin
                    if (go)
                    begin
                        // a run ends: first scan finds the max, second emits
                        if (run_close)
                        begin
                            if (!pass2_reg)
                            begin
                                if (run_reg > best_reg)
                                begin
                                    best_reg <= run_reg;
                                    ties_reg <= CW'(1);
                                end
                                else if (run_reg == best_reg)
                                begin
                                    ties_reg <= ties_reg + 1'b1;
                                end
                            end
                            else if (qualifies)
                            begin
                                out_valid_reg      <= 1'b1;
                                out_reg.mode_value <= prev_reg;
                                out_reg.max_count  <= COUNT_W'(best_reg);
                                out_reg.overflow   <= dropped_reg;
                                out_reg.final_res  <= (emitted_inc == ties_reg);
                                emitted_reg        <= emitted_inc;
                            end
                        end

                        if (at_end)
                        begin
                            if (!pass2_reg)
                            begin
                                pass2_reg <= 1'b1;
                                state_reg <= S_CNT_RD0;
                            end
                            else
                            begin
                                count_reg   <= '0;
                                dropped_reg <= 1'b0;
                                state_reg   <= S_LOAD;
                            end
                        end
                        else
                        begin
                            if (run_close)
                            begin
                                prev_reg <= ram_rdata;
                                run_reg  <= CW'(1);
                            end
                            else
                            begin
                                run_reg <= run_reg + 1'b1;
                            end
                            k_reg <= k_inc;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule : array_mode_finder

`default_nettype wire
